[rtl/core/hlu_pkg.sv]
package hlu_pkg;

  // Default sample width, Q1.(SAMPLE_BITS-1).
  localparam int SAMPLE_BITS_DEF = 32;

  // Configuration register widths and indexes.
  localparam int FACTOR_BITS = 7;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FACTOR = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORDER = 1'b1;

  // Legal range of the upsampling factor.
  localparam logic [FACTOR_BITS-1:0] FACTOR_MIN = 7'd2;
  localparam logic [FACTOR_BITS-1:0] FACTOR_MAX = 7'd64;
  localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 7'd2;

  // Interpolation orders.
  localparam logic ORDER_HOLD = 1'b0;
  localparam logic ORDER_LINEAR = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } hlu_state_t;

  // Bring a factor into the legal range.
  function automatic logic [FACTOR_BITS-1:0] clamp_factor(input logic [FACTOR_BITS-1:0] f);
    logic [FACTOR_BITS-1:0] res;
    res = f;
    if (f < FACTOR_MIN) res = FACTOR_MIN;
    if (f > FACTOR_MAX) res = FACTOR_MAX;
    return res;
  endfunction

endpackage

[rtl/core/hlu_div.sv]
module hlu_div #(
  parameter int SAMPLE_BITS = hlu_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [SAMPLE_BITS-1:0]        dividend,
  input  logic [hlu_pkg::FACTOR_BITS-1:0] divisor,
  output logic                          done,
  output logic [SAMPLE_BITS-1:0]        quo,
  output logic [hlu_pkg::FACTOR_BITS-1:0] rem
);
  import hlu_pkg::*;

  localparam int CNT_W = $clog2(SAMPLE_BITS);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [SAMPLE_BITS-1:0] quo_r, quo_nxt;
  logic [FACTOR_BITS-1:0] rem_r, rem_nxt;
  logic [FACTOR_BITS-1:0] div_r, div_nxt;
  logic [FACTOR_BITS:0]   shifted;
  logic [FACTOR_BITS:0]   diff;
  logic                   ge;

  // One restoring step: bring down the next dividend bit and try the subtract.
  assign shifted = {rem_r, quo_r[SAMPLE_BITS-1]};
  assign ge = shifted >= {1'b0, div_r};
  assign diff = shifted - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      quo_nxt = dividend;
      rem_nxt = '0;
      div_nxt = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[SAMPLE_BITS-2:0], ge};
      rem_nxt = ge ? diff[FACTOR_BITS-1:0] : shifted[FACTOR_BITS-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(SAMPLE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the data path is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign quo = quo_r;
  assign rem = rem_r;

  // The remainder always ends below the divisor.
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  // Done is a single-cycle pulse.
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held for more than one cycle");

  // A new division is only started when the unit is free.
  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

endmodule

[rtl/core/hold_or_linear_upsampler_top.sv]
// Integer-factor upsampler with sample hold or linear interpolation.
// Input beats (in_sample, in_discontinuity) are taken on in_valid while
// in_stall is low; result beats (out_sample, out_last_of_run) leave on
// out_valid while out_stall is low. Configuration is written through
// cfg_we / cfg_index / cfg_wdata: index 0 is the factor (clamped to 2..64),
// index 1 the order (0 hold, 1 linear), both taking effect on the next beat.
// In hold mode a beat gives factor results at one per cycle while the
// receiver does not stall. In linear mode a serial restoring divider
// first forms |new - prev| / factor, one quotient bit per cycle, before
// the run; the first beat after reset or a discontinuity only primes the
// stored sample and gives nothing. The results are then stepped out by
// one shared adder that adds the quotient plus a carry from the
// accumulated remainder.
// The block takes one beat at a time; the next beat is accepted once the
// last result of the run sits in the output register. When the receiver
// stalls, the output register holds and the run pauses.
// Synchronous reset returns factor 2, hold mode and no stored sample.
module hold_or_linear_upsampler_top #(
  parameter int SAMPLE_BITS = hlu_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample,
  input  logic                             in_discontinuity,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_BITS-1:0]    out_sample,
  output logic                             out_last_of_run,
  input  logic                             cfg_we,
  input  logic [hlu_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [hlu_pkg::FACTOR_BITS-1:0]  cfg_wdata
);
  import hlu_pkg::*;

  localparam int CNT_BITS = FACTOR_BITS - 1;

  hlu_state_t state_r, state_nxt;

  logic [FACTOR_BITS-1:0] cfg_factor_r;
  logic                   cfg_order_r;

  logic [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic                   prev_valid_r, prev_valid_nxt;
  logic [SAMPLE_BITS-1:0] point_r, point_nxt;
  logic                   down_r, down_nxt;
  logic [SAMPLE_BITS-1:0] q_r, q_nxt;
  logic [FACTOR_BITS-1:0] r_r, r_nxt;
  logic [FACTOR_BITS-1:0] f_r, f_nxt;
  logic [FACTOR_BITS-1:0] rem_acc_r, rem_acc_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   in_acc;
  logic                   slot_free;
  logic [FACTOR_BITS-1:0] f_cur;
  logic                   is_down;
  logic [SAMPLE_BITS-1:0] mag;
  logic [FACTOR_BITS:0]   sum;
  logic [FACTOR_BITS:0]   sum_wrap;
  logic                   carry;
  logic [SAMPLE_BITS-1:0] step;
  logic                   last;

  logic                   div_start;
  logic                   div_done;
  logic [SAMPLE_BITS-1:0] div_quo;
  logic [FACTOR_BITS-1:0] div_rem;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_factor_r <= FACTOR_RESET;
      cfg_order_r <= ORDER_HOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FACTOR: cfg_factor_r <= cfg_wdata;
        REG_ORDER:  cfg_order_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign f_cur = clamp_factor(cfg_factor_r);

  // Direction and magnitude of the slope from the stored sample.
  assign is_down = $signed(in_sample) < $signed(prev_r);
  assign mag = is_down ? (prev_r - in_sample) : (in_sample - prev_r);

  // Shared stepping adder: quotient plus a carry from the remainder sum.
  assign sum = {1'b0, rem_acc_r} + {1'b0, r_r};
  assign sum_wrap = sum - {1'b0, f_r};
  assign carry = sum >= {1'b0, f_r};
  assign step = q_r + SAMPLE_BITS'(carry);
  assign last = ({1'b0, cnt_r} == (f_r - FACTOR_BITS'(1)));

  hlu_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (f_cur),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Sequencer: next state and data path control.
  always_comb begin
    state_nxt = state_r;
    prev_nxt = prev_r;
    prev_valid_nxt = prev_valid_r;
    point_nxt = point_r;
    down_nxt = down_r;
    q_nxt = q_r;
    r_nxt = r_r;
    f_nxt = f_r;
    rem_acc_nxt = rem_acc_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;
    out_last_nxt = out_last_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          prev_nxt = in_sample;
          prev_valid_nxt = 1'b1;
          f_nxt = f_cur;
          rem_acc_nxt = '0;
          cnt_nxt = '0;
          if (cfg_order_r == ORDER_HOLD) begin
            point_nxt = in_sample;
            down_nxt = 1'b0;
            q_nxt = '0;
            r_nxt = '0;
            state_nxt = ST_EMIT;
          end else if (prev_valid_r && !in_discontinuity) begin
            point_nxt = prev_r;
            down_nxt = is_down;
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          q_nxt = div_quo;
          r_nxt = div_rem;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_sample_nxt = point_r;
          out_last_nxt = last;
          point_nxt = down_r ? (point_r - step) : (point_r + step);
          rem_acc_nxt = carry ? sum_wrap[FACTOR_BITS-1:0] : sum[FACTOR_BITS-1:0];
          cnt_nxt = cnt_r + CNT_BITS'(1);
          if (last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      prev_r <= '0;
      prev_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
      rem_acc_r <= '0;
      f_r <= FACTOR_RESET;
    end else begin
      state_r <= state_nxt;
      prev_r <= prev_nxt;
      prev_valid_r <= prev_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r <= cnt_nxt;
      rem_acc_r <= rem_acc_nxt;
      f_r <= f_nxt;
    end
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    point_r <= point_nxt;
    down_r <= down_nxt;
    q_r <= q_nxt;
    r_r <= r_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last_of_run = out_last_r;

  // A pending result that is not the last of its run means the run is still going.
  a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == ST_EMIT))
    else $error("non-final result pending outside a run");

  // The divider only reports while the sequencer waits for it.
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // The accumulated remainder stays below the factor while stepping.
  a_rem_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (rem_acc_r < f_r))
    else $error("remainder accumulator reached the factor");

endmodule

[tb/hold_or_linear_upsampler_top_tb.sv]
`timescale 1ns / 100ps

module hold_or_linear_upsampler_top_tb;
  import hlu_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  // A linear beat takes the divider plus the run; this covers a beat that shows nothing.
  localparam int SETTLE_CYCLES = SB + 2 * 64 + 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASES = 15;
  localparam int BEATS_PER_PHASE = 30;

  typedef enum logic {
    ROW_WRITE,
    ROW_BEAT
  } row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [FACTOR_BITS-1:0] wdata;
    logic [SB-1:0] sample;
    logic disc;
    bit known;
    logic [SB-1:0] known_val;
  } script_row_t;

  typedef struct {
    logic signed [SB-1:0] sample;
    logic last;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SB-1:0] in_sample = '0;
  logic in_discontinuity = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SB-1:0] out_sample;
  logic out_last_of_run;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [FACTOR_BITS-1:0] cfg_wdata = '0;

  // Shadow of the block's registers and stored sample.
  logic [FACTOR_BITS-1:0] factor_reg = FACTOR_RESET;
  logic order_reg = ORDER_HOLD;
  logic [SB-1:0] prev_sample = '0;
  bit prev_valid = 1'b0;

  point_t pending_points[$];
  script_row_t script[$];

  bit calm = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_off_taken = 1'b0;
  int hold_off_left = 0;
  int failures = 0;
  int beats_sent = 0;
  int points_seen = 0;
  int settings_used = 0;

  hold_or_linear_upsampler_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .in_discontinuity(in_discontinuity),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample(out_sample),
    .out_last_of_run(out_last_of_run),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Work out the run of output samples that one accepted beat causes.
  function automatic void upsample_beat(input logic [SB-1:0] s, input logic disc,
                                        input bit known, input logic [SB-1:0] kv);
    longint p, n, mag, q, r, m;
    int f;
    point_t pt;
    f = int'(factor_reg);
    if (f < int'(FACTOR_MIN)) f = int'(FACTOR_MIN);
    if (f > int'(FACTOR_MAX)) f = int'(FACTOR_MAX);
    if (order_reg == ORDER_HOLD || (prev_valid && !disc)) begin
      p = longint'($signed(prev_sample));
      n = longint'($signed(s));
      mag = (n < p) ? p - n : n - p;
      q = mag / f;
      r = mag % f;
      for (int i = 0; i < f; i++) begin
        // Split the slope so the product never loses the remainder.
        m = q * i + (r * i) / f;
        if (order_reg == ORDER_HOLD) pt.sample = s;
        else pt.sample = SB'((n < p) ? p - m : p + m);
        if (known) pt.sample = kv;
        pt.last = (i == f - 1);
        pending_points.push_back(pt);
      end
    end
    prev_sample = s;
    prev_valid = 1'b1;
  endfunction

  function automatic void add_write(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [FACTOR_BITS-1:0] val);
    script_row_t row;
    row = '{ROW_WRITE, idx, val, '0, 1'b0, 1'b0, '0};
    script.push_back(row);
  endfunction

  function automatic void add_beat(input logic [SB-1:0] s, input logic d,
                                   input bit known, input logic [SB-1:0] kv);
    script_row_t row;
    row = '{ROW_BEAT, '0, '0, s, d, known, kv};
    script.push_back(row);
  endfunction

  // Some extremes, many small steps from the stored sample, the rest anywhere.
  function automatic logic [SB-1:0] pick_sample(input logic [SB-1:0] near);
    int sel;
    logic [SB-1:0] res;
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(4))
        0: res = {1'b1, {(SB-1){1'b0}}};
        1: res = {1'b0, {(SB-1){1'b1}}};
        2: res = '0;
        3: res = '1;
        default: res = SB'(1);
      endcase
    end else if (sel < 50) begin
      res = near + SB'($urandom_range(400)) - SB'(200);
    end else begin
      res = SB'($urandom);
    end
    return res;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [FACTOR_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_FACTOR) factor_reg = val;
    else order_reg = val[0];
    settings_used++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every expected sample is out and the block has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_beat(input logic [SB-1:0] s, input logic d,
                           input bit known, input logic [SB-1:0] kv);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_discontinuity <= d;
    do @(posedge clk); while (in_stall);
    upsample_beat(s, d, known, kv);
    beats_sent++;
    @(negedge clk);
  endtask

  // Receiver: random stalls, one long hold-off on request, none when calm.
  always @(negedge clk) begin
    if (hold_off_left != 0) begin
      hold_off_left = hold_off_left - 1;
      out_stall <= 1'b1;
    end else if (hold_off_req && !hold_off_taken) begin
      hold_off_taken = 1'b1;
      hold_off_left = HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 8);
    end
  end

  // Compare each output beat with the oldest expected sample.
  always @(posedge clk) begin : watch_results
    point_t want;
    if (rst_n && out_valid && !out_stall) begin
      points_seen++;
      if (pending_points.size() == 0) begin
        $error("out_sample: expected nothing, actual %0d", out_sample);
        failures++;
      end else begin
        want = pending_points.pop_front();
        if (out_sample !== want.sample) begin
          $error("out_sample: expected %0d, actual %0d", want.sample, out_sample);
          failures++;
        end
        if (out_last_of_run !== want.last) begin
          $error("out_last_of_run: expected %0b, actual %0b", want.last, out_last_of_run);
          failures++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    script_row_t row;
    logic [FACTOR_BITS-1:0] f_w;
    int sel;

    // Linear from reset: the first beat only primes, then full-scale swings.
    add_write(REG_ORDER, FACTOR_BITS'(ORDER_LINEAR));
    add_beat(32'h7FFF_FFFF, 1'b0, 1'b0, '0);
    add_beat(32'h8000_0000, 1'b0, 1'b0, '0);
    add_beat(32'h7FFF_FFFF, 1'b0, 1'b0, '0);
    add_write(REG_FACTOR, FACTOR_MAX);
    // A discontinuity primes again; then full-scale swings and a slope below the factor, whose quotient is zero.
    add_beat(32'h8000_0000, 1'b1, 1'b0, '0);
    add_beat(32'h7FFF_FFFF, 1'b0, 1'b0, '0);
    add_beat(32'hFFFF_FFF9, 1'b0, 1'b0, '0);
    add_beat(32'h0000_0007, 1'b0, 1'b0, '0);
    // Hold mode through the low bit only; the discontinuity changes nothing.
    add_write(REG_ORDER, 7'h7E);
    add_beat(32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000);
    add_beat(32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF);
    add_beat(32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000);
    add_write(REG_FACTOR, 7'd0);
    add_beat(32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
    add_write(REG_FACTOR, 7'd127);
    add_beat(32'h5555_5555, 1'b0, 1'b1, 32'h5555_5555);
    // Back to linear: it starts from the sample stored while holding.
    add_write(REG_ORDER, 7'h7F);
    add_beat(32'hAAAA_AAAA, 1'b0, 1'b0, '0);
    add_write(REG_FACTOR, 7'd1);
    add_beat(32'hFFFF_FF9C, 1'b0, 1'b0, '0);
    add_beat(32'h0000_0064, 1'b0, 1'b0, '0);
    add_write(REG_FACTOR, 7'd65);
    add_beat(32'h0000_0064, 1'b0, 1'b0, '0);
    add_beat(32'h8000_0001, 1'b0, 1'b0, '0);
    add_write(REG_FACTOR, 7'd3);
    add_beat(32'h0000_0001, 1'b0, 1'b0, '0);
    add_beat(32'hFFFF_FFFF, 1'b0, 1'b0, '0);
    add_beat(32'h0000_0002, 1'b0, 1'b0, '0);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[k]) begin
      row = script[k];
      if (row.kind == ROW_WRITE) begin
        drain();
        write_reg(row.idx, row.wdata);
      end else begin
        send_beat(row.sample, row.disc, row.known, row.known_val);
      end
    end

    // Random settings, mostly small factors; one phase with a long output hold-off.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      sel = $urandom_range(19);
      if (sel < 12) f_w = FACTOR_BITS'($urandom_range(8, 2));
      else if (sel < 15) f_w = FACTOR_BITS'($urandom_range(63, 9));
      else if (sel < 17) f_w = FACTOR_MAX;
      else if (sel < 18) f_w = FACTOR_BITS'($urandom_range(1));
      else f_w = FACTOR_BITS'($urandom_range(127, 65));
      write_reg(REG_FACTOR, f_w);
      write_reg(REG_ORDER, {6'($urandom_range(63)), 1'($urandom_range(1))});
      calm = (ph >= 5 && ph <= 7);
      if (ph == 2) hold_off_req = 1'b1;
      for (int k = 0; k < BEATS_PER_PHASE; k++)
        send_beat(pick_sample(prev_sample), $urandom_range(9) == 0, 1'b0, '0);
    end
    calm = 1'b0;

    drain();
    $display("Sent %0d input beats over %0d register writes, checked %0d output beats,",
             beats_sent, settings_used, points_seen);
    $display("covering hold and linear runs, clamped factors and one long output hold-off.");
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
